// ----- hdl/crv_pkg.sv -----
package crv_pkg;

  // store geometry
  localparam int VOICES         = 8;
  localparam int MAX_LOG2_CELLS = 12;
  localparam int VOICE_W        = $clog2(VOICES);
  localparam int CELL_W         = MAX_LOG2_CELLS;
  localparam int ADDR_W         = VOICE_W + CELL_W;
  localparam int DEPTH          = VOICES << CELL_W;

  // field widths
  localparam int DATA_W   = 18;
  localparam int POS_W    = 18;
  localparam int MODE_W   = 3;
  localparam int LOG2_W   = 4;
  localparam int REG_IDX_W = 2;

  // Q2.15: 1.0 is ONE_Q, and a position spans 2.0, i.e. 2^POS_SHIFT
  localparam int ONE_Q     = 32768;
  localparam int POS_SHIFT = 16;
  localparam int SHIFT_W   = 5;

  // write addressing modes
  localparam logic [MODE_W-1:0] MODE_DIRECT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UP        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_UP_FILL   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DOWN      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DOWN_FILL = 3'd4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ADDR_MODE       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_LOG2       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [MODE_W-1:0]        ADDR_MODE_RESET = MODE_UP;
  localparam logic [LOG2_W-1:0]        SIZE_LOG2_RESET = 4'd12;
  localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = -18'sd3277;

  typedef struct packed {
    logic [MODE_W-1:0]        addr_mode;
    logic [LOG2_W-1:0]        size_log2;
    logic signed [DATA_W-1:0] write_threshold;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLAN,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_t;

  // floor(cells*(p+1)/2) clamped to 0..cells-1
  function automatic logic [CELL_W-1:0] pos_to_cell(input logic signed [POS_W-1:0] pos,
                                                    input logic [LOG2_W-1:0] size);
    logic signed [POS_W:0] shifted;
    logic [LOG2_W-1:0]     lg;
    logic [POS_W-1:0]      scaled;
    logic [POS_W-1:0]      top;
    lg = (size > LOG2_W'(MAX_LOG2_CELLS)) ? LOG2_W'(MAX_LOG2_CELLS) : size;
    shifted = {pos[POS_W-1], pos} + (POS_W+1)'(ONE_Q);
    scaled = shifted[POS_W-1:0] >> (SHIFT_W'(POS_SHIFT) - SHIFT_W'(lg));
    top = (POS_W'(1) << lg) - POS_W'(1);
    if (scaled > top) begin
      scaled = top;
    end
    if (shifted[POS_W] || (shifted == '0)) begin
      scaled = '0;
    end
    return scaled[CELL_W-1:0];
  endfunction

endpackage

// ----- hdl/crv_store.sv -----
module crv_store (
  input  logic                         clk,
  input  crv_pkg::mem_req_t            req,
  output logic [crv_pkg::DATA_W-1:0]   rd_data
);

  logic [crv_pkg::DATA_W-1:0] mem [crv_pkg::DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

// ----- hdl/crv_seq.sv -----
module crv_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [crv_pkg::VOICE_W-1:0]        voice,
  input  logic signed [crv_pkg::DATA_W-1:0]  sample_in,
  input  logic signed [crv_pkg::POS_W-1:0]   write_position,
  input  logic signed [crv_pkg::DATA_W-1:0]  write_enable,
  input  logic signed [crv_pkg::POS_W-1:0]   read_position,
  input  crv_pkg::cfg_t                      cfg,
  input  logic [crv_pkg::DATA_W-1:0]         rd_data,
  output crv_pkg::mem_req_t                  req,
  output logic                               busy,
  output logic                               done,
  output logic signed [crv_pkg::DATA_W-1:0]  sample_out
);

  crv_pkg::state_t state, state_next;

  logic [crv_pkg::ADDR_W-1:0]  clr_addr;
  logic [crv_pkg::CELL_W-1:0]  last_idx [crv_pkg::VOICES];
  logic [crv_pkg::VOICE_W-1:0] item_voice;
  logic [crv_pkg::DATA_W-1:0]  item_sample;
  logic [crv_pkg::CELL_W-1:0]  wr_idx;
  logic [crv_pkg::CELL_W-1:0]  rd_idx;
  logic                        wr_ok;
  logic                        voice_ok;
  logic [crv_pkg::CELL_W-1:0]  cursor;

  logic [crv_pkg::CELL_W-1:0]  last;
  logic [crv_pkg::CELL_W-1:0]  first;
  logic                        go;
  logic                        step_down;

  // write plan from the mode and the voice's last write index
  always_comb begin
    last = last_idx[item_voice];
    first = wr_idx;
    go = 1'b0;
    unique case (cfg.addr_mode)
      crv_pkg::MODE_DIRECT: go = 1'b1;
      crv_pkg::MODE_UP: go = (wr_idx > last);
      crv_pkg::MODE_DOWN: go = (wr_idx < last);
      crv_pkg::MODE_UP_FILL: begin
        go = (wr_idx > last);
        first = last + crv_pkg::CELL_W'(1);
      end
      crv_pkg::MODE_DOWN_FILL: begin
        go = (wr_idx < last);
        first = last - crv_pkg::CELL_W'(1);
      end
      default: go = 1'b0;
    endcase
    go = go & wr_ok & voice_ok;
    step_down = (cfg.addr_mode == crv_pkg::MODE_DOWN_FILL);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crv_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port
  always_comb begin
    state_next = state;
    req.we = 1'b0;
    req.waddr = {item_voice, cursor};
    req.wdata = item_sample;
    req.raddr = {item_voice, rd_idx};
    busy = (state != crv_pkg::ST_IDLE);
    done = 1'b0;
    unique case (state)
      crv_pkg::ST_CLEAR: begin
        req.we = 1'b1;
        req.waddr = clr_addr;
        req.wdata = '0;
        if (clr_addr == crv_pkg::ADDR_W'(crv_pkg::DEPTH - 1)) begin
          state_next = crv_pkg::ST_IDLE;
        end
      end
      crv_pkg::ST_IDLE: begin
        if (start) begin
          state_next = crv_pkg::ST_PLAN;
        end
      end
      crv_pkg::ST_PLAN: begin
        state_next = go ? crv_pkg::ST_FILL : crv_pkg::ST_READ;
      end
      crv_pkg::ST_FILL: begin
        req.we = 1'b1;
        if (cursor == wr_idx) begin
          state_next = crv_pkg::ST_READ;
        end
      end
      crv_pkg::ST_READ: begin
        state_next = crv_pkg::ST_RESP;
      end
      crv_pkg::ST_RESP: begin
        done = 1'b1;
        state_next = crv_pkg::ST_IDLE;
      end
      default: state_next = crv_pkg::ST_IDLE;
    endcase
  end

  // item registers, clear counter and last write indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      for (int v = 0; v < crv_pkg::VOICES; v++) begin
        last_idx[v] <= '0;
      end
    end else begin
      unique case (state)
        crv_pkg::ST_CLEAR: clr_addr <= clr_addr + crv_pkg::ADDR_W'(1);
        crv_pkg::ST_IDLE: begin
          if (start) begin
            item_voice  <= voice;
            item_sample <= sample_in;
            wr_idx      <= crv_pkg::pos_to_cell(write_position, cfg.size_log2);
            rd_idx      <= crv_pkg::pos_to_cell(read_position, cfg.size_log2);
            wr_ok       <= (write_enable >= cfg.write_threshold);
            voice_ok    <= (32'(voice) < crv_pkg::VOICES);
          end
        end
        crv_pkg::ST_PLAN: begin
          cursor <= first;
          if (voice_ok) begin
            last_idx[item_voice] <= wr_idx;
          end
        end
        crv_pkg::ST_FILL: begin
          cursor <= step_down ? cursor - crv_pkg::CELL_W'(1) : cursor + crv_pkg::CELL_W'(1);
        end
        default: ;
      endcase
    end
  end

  // result beat
  assign sample_out = voice_ok ? rd_data : '0;

endmodule

// ----- hdl/cv_recorder_memory.sv -----
// Per-voice control-voltage recorder memory, 8 voices of 4096 cells of 18 bits.
// Input beat: start with the item fields, taken at a clock edge where start is
// high and busy is low. Result beat: sample_out is valid for exactly one cycle
// while done is high; the receiver takes it then and cannot hold it off.
// Configuration: reg_write with reg_index and reg_data writes a register at once
// (0 addr_mode, 1 size_log2, 2 write_threshold); write only while busy is low.
// Flow: an item that writes n cells (n = 0 when no write happens, 1 for a
// single write, up to 4095 for a fill) goes through the plan state, the fill
// state when n > 0, then the read and result states; busy stays high until the
// result beat ends, so no new item is taken before it. With the single write
// port, fills walk one cell per cycle before the result cell's registered read.
// Reset: the store is cleared by a pass over its 32768 cells, one per cycle;
// busy stays high until it ends. Configuration registers and last write
// indexes return to their defaults at once.
module cv_recorder_memory (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [crv_pkg::VOICE_W-1:0]         voice,
  input  logic signed [crv_pkg::DATA_W-1:0]   sample_in,
  input  logic signed [crv_pkg::POS_W-1:0]    write_position,
  input  logic signed [crv_pkg::DATA_W-1:0]   write_enable,
  input  logic signed [crv_pkg::POS_W-1:0]    read_position,
  output logic                                done,
  output logic signed [crv_pkg::DATA_W-1:0]   sample_out,
  input  logic                                reg_write,
  input  logic [crv_pkg::REG_IDX_W-1:0]       reg_index,
  input  logic [crv_pkg::DATA_W-1:0]          reg_data
);

  crv_pkg::cfg_t     cfg;
  crv_pkg::mem_req_t req;
  logic [crv_pkg::DATA_W-1:0] rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.addr_mode       <= crv_pkg::ADDR_MODE_RESET;
      cfg.size_log2       <= crv_pkg::SIZE_LOG2_RESET;
      cfg.write_threshold <= crv_pkg::THRESHOLD_RESET;
    end else if (reg_write) begin
      unique case (reg_index)
        crv_pkg::REG_ADDR_MODE: cfg.addr_mode <= reg_data[crv_pkg::MODE_W-1:0];
        crv_pkg::REG_SIZE_LOG2: cfg.size_log2 <= reg_data[crv_pkg::LOG2_W-1:0];
        crv_pkg::REG_WRITE_THRESHOLD: cfg.write_threshold <= reg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  crv_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .voice          (voice),
    .sample_in      (sample_in),
    .write_position (write_position),
    .write_enable   (write_enable),
    .read_position  (read_position),
    .cfg            (cfg),
    .rd_data        (rd_data),
    .req            (req),
    .busy           (busy),
    .done           (done),
    .sample_out     (sample_out)
  );

  // sample store
  crv_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

// ----- verif/cv_recorder_memory_checker.sv -----
module cv_recorder_memory_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [crv_pkg::VOICE_W-1:0]       voice,
  input  logic signed [crv_pkg::DATA_W-1:0] sample_in,
  input  logic signed [crv_pkg::POS_W-1:0]  write_position,
  input  logic signed [crv_pkg::DATA_W-1:0] write_enable,
  input  logic signed [crv_pkg::POS_W-1:0]  read_position,
  input  logic                              done,
  input  logic signed [crv_pkg::DATA_W-1:0] sample_out,
  input  logic                              reg_write,
  input  logic [crv_pkg::REG_IDX_W-1:0]     reg_index,
  input  logic [crv_pkg::DATA_W-1:0]        reg_data,
  output int                                errors,
  output int                                pending
);
  import crv_pkg::*;

  // shadow of the recorder state and its registers
  logic [DATA_W-1:0]        recorded_cells [DEPTH];
  logic [CELL_W-1:0]        last_cell [VOICES];
  logic [MODE_W-1:0]        addr_mode;
  logic [LOG2_W-1:0]        size_log2;
  logic signed [DATA_W-1:0] write_threshold;
  logic [DATA_W-1:0]        expected_readouts [$];

  // map a Q2.15 position onto a cell of a 2^lg store, clamped at both ends
  function automatic int unsigned cell_at(input logic signed [POS_W-1:0] pos,
                                          input int unsigned lg);
    int offset;
    int unsigned span;
    offset = int'(pos) + ONE_Q;
    span   = 1 << lg;
    if (offset <= 0) begin
      return 0;
    end
    offset = offset >>> (POS_SHIFT - lg);
    if (offset >= int'(span)) begin
      return span - 1;
    end
    return offset;
  endfunction

  // apply one item's write, then queue the cell that its read will return
  task automatic record_and_read(input logic [VOICE_W-1:0] v,
                                 input logic [DATA_W-1:0] s,
                                 input logic signed [POS_W-1:0] wpos,
                                 input logic signed [DATA_W-1:0] wena,
                                 input logic signed [POS_W-1:0] rpos);
    int unsigned lg, base, last, widx, ridx;
    lg   = (size_log2 > MAX_LOG2_CELLS) ? MAX_LOG2_CELLS : size_log2;
    base = int'(v) << CELL_W;
    last = last_cell[v];
    widx = cell_at(wpos, lg);
    if (wena >= write_threshold) begin
      case (addr_mode)
        MODE_DIRECT: begin
          recorded_cells[base + widx] = s;
        end
        MODE_UP: begin
          if (widx > last) recorded_cells[base + widx] = s;
        end
        MODE_UP_FILL: begin
          if (widx > last) begin
            for (int unsigned i = last + 1; i <= widx; i++) recorded_cells[base + i] = s;
          end
        end
        MODE_DOWN: begin
          if (widx < last) recorded_cells[base + widx] = s;
        end
        MODE_DOWN_FILL: begin
          if (widx < last) begin
            for (int unsigned i = last; i > widx; i--) recorded_cells[base + i - 1] = s;
          end
        end
        default: begin
        end
      endcase
    end
    last_cell[v] = CELL_W'(widx);
    ridx = cell_at(rpos, lg);
    expected_readouts.push_back(recorded_cells[base + ridx]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) recorded_cells[i] = '0;
      for (int i = 0; i < VOICES; i++) last_cell[i] = '0;
      addr_mode       = ADDR_MODE_RESET;
      size_log2       = SIZE_LOG2_RESET;
      write_threshold = THRESHOLD_RESET;
      expected_readouts.delete();
      errors = 0;
    end else begin
      // result beat against the oldest expectation
      if (done) begin
        if (expected_readouts.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected result beat: sample_out %0d", sample_out);
          end
          errors++;
        end else begin
          if (sample_out !== expected_readouts[0]) begin
            if (errors < 10) begin
              $display("sample_out mismatch: expected %0d, got %0d",
                       $signed(expected_readouts[0]), sample_out);
            end
            errors++;
          end
          void'(expected_readouts.pop_front());
        end
      end
      // accepted input beat
      if (start && !busy) begin
        record_and_read(voice, sample_in, write_position, write_enable, read_position);
      end
      // register writes
      if (reg_write) begin
        case (reg_index)
          REG_ADDR_MODE:       addr_mode = reg_data[MODE_W-1:0];
          REG_SIZE_LOG2:       size_log2 = reg_data[LOG2_W-1:0];
          REG_WRITE_THRESHOLD: write_threshold = reg_data;
          default: begin
          end
        endcase
      end
    end
    pending = expected_readouts.size();
  end

endmodule

// ----- verif/cv_recorder_memory_tb.sv -----
module cv_recorder_memory_tb;
  import crv_pkg::*;

  localparam int FIELD_MAX   = (1 << (DATA_W - 1)) - 1;
  localparam int FIELD_MIN   = -(1 << (DATA_W - 1));
  localparam int QUIET_LIMIT = 200000;
  localparam int PHASES      = 24;

  // modes with no write behind them
  localparam logic [MODE_W-1:0] MODE_REFLECTED = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7   = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [VOICE_W-1:0]       voice;
  logic signed [DATA_W-1:0] sample_in;
  logic signed [POS_W-1:0]  write_position;
  logic signed [DATA_W-1:0] write_enable;
  logic signed [POS_W-1:0]  read_position;
  logic                     done;
  logic signed [DATA_W-1:0] sample_out;
  logic                     reg_write;
  logic [REG_IDX_W-1:0]     reg_index;
  logic [DATA_W-1:0]        reg_data;
  int                       errors;
  int                       pending;
  int                       quiet_cycles = 0;
  int                       sweep [VOICES];

  always #10 clk = ~clk;

  cv_recorder_memory i_dut (
    .clk, .rst, .start, .busy, .voice, .sample_in, .write_position, .write_enable,
    .read_position, .done, .sample_out, .reg_write, .reg_index, .reg_data
  );

  cv_recorder_memory_checker i_checker (
    .clk, .rst, .start, .busy, .voice, .sample_in, .write_position, .write_enable,
    .read_position, .done, .sample_out, .reg_write, .reg_index, .reg_data,
    .errors, .pending
  );

  // watchdog: too long without any beat or register write
  always @(posedge clk) begin
    if ((start && !busy) || done || reg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat, held until the block takes it; start stays high afterwards
  task automatic issue(input int v, input int s, input int wp, input int we, input int rp);
    start          <= 1'b1;
    voice          <= VOICE_W'(v);
    sample_in      <= DATA_W'(s);
    write_position <= POS_W'(wp);
    write_enable   <= DATA_W'(we);
    read_position  <= POS_W'(rp);
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // all three registers, once the block has drained
  task automatic set_config(input logic [MODE_W-1:0] mode, input int size, input int thr);
    start <= 1'b0;
    while (busy || pending != 0) @(negedge clk);
    reg_write <= 1'b1;
    reg_index <= REG_ADDR_MODE;
    reg_data  <= DATA_W'(mode);
    @(negedge clk);
    reg_index <= REG_SIZE_LOG2;
    reg_data  <= DATA_W'(size);
    @(negedge clk);
    reg_index <= REG_WRITE_THRESHOLD;
    reg_data  <= DATA_W'(thr);
    @(negedge clk);
    reg_write <= 1'b0;
  endtask

  // position anywhere: in span, full field, or a corner
  function automatic int any_position(input int k);
    if (k <= 7) begin
      return int'($urandom_range(2 * ONE_Q - 1)) - ONE_Q;
    end
    if (k == 8) begin
      return int'(POS_W'($signed($urandom)));
    end
    case ($urandom_range(6))
      0: return FIELD_MIN;
      1: return FIELD_MAX;
      2: return -ONE_Q;
      3: return -ONE_Q - 1;
      4: return ONE_Q - 1;
      5: return ONE_Q;
      default: return 0;
    endcase
  endfunction

  // random beat, mostly a per-voice sweep in the direction the mode records
  task automatic random_item(input logic [MODE_W-1:0] mode, input int lg, input int thr);
    int v, wp, we, rp, k, dir, cell_q;
    v      = $urandom_range(VOICES - 1);
    cell_q = (1 << POS_SHIFT) >> lg;
    k      = $urandom_range(9);
    if (k < 6) begin
      if (mode == MODE_UP || mode == MODE_UP_FILL) dir = 1;
      else if (mode == MODE_DOWN || mode == MODE_DOWN_FILL) dir = -1;
      else dir = $urandom_range(1) ? 1 : -1;
      sweep[v] += dir * int'($urandom_range(2 * cell_q));
      if (sweep[v] >= ONE_Q) sweep[v] = -ONE_Q;
      else if (sweep[v] < -ONE_Q) sweep[v] = ONE_Q - 1;
      wp = sweep[v];
    end else begin
      wp = any_position(k);
    end
    // enable level around the threshold
    k = $urandom_range(9);
    if (k < 7) we = thr + int'($urandom_range(FIELD_MAX - thr));
    else if (k == 7) we = thr;
    else if (k == 8 && thr > FIELD_MIN) we = thr - 1 - int'($urandom_range(thr - FIELD_MIN - 1));
    else we = int'(DATA_W'($signed($urandom)));
    k  = $urandom_range(5, 10);
    rp = (k == 10) ? wp : any_position(k);
    issue(v, int'($urandom), wp, we, rp);
  endtask

  initial begin
    logic [MODE_W-1:0] mode;
    int                size, thr, count, idle_pct, lg;
    rst            = 1'b1;
    start          = 1'b0;
    voice          = '0;
    sample_in      = '0;
    write_position = '0;
    write_enable   = '0;
    read_position  = '0;
    reg_write      = 1'b0;
    reg_index      = '0;
    reg_data       = '0;
    for (int i = 0; i < VOICES; i++) sweep[i] = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed: default registers, field extremes, enable at and just under threshold
    issue(0, FIELD_MAX, FIELD_MAX, -3277, FIELD_MAX);
    issue(0, FIELD_MIN, FIELD_MIN, FIELD_MAX, FIELD_MIN);
    issue(7, -1, ONE_Q - 1, -3278, ONE_Q - 1);
    issue(7, 12345, 0, 0, 0);
    issue(1, FIELD_MIN, -ONE_Q, 0, -ONE_Q - 1);
    // shrunken size: down fill walks from the index left by the full size
    set_config(MODE_DOWN_FILL, 2, FIELD_MIN);
    issue(7, 777, FIELD_MIN, FIELD_MIN, ONE_Q / 2);
    issue(7, -5, FIELD_MAX, 5, -ONE_Q / 2);
    set_config(MODE_UP_FILL, 3, 0);
    issue(2, 1000, 0, 0, ONE_Q - 1);
    issue(2, 2000, ONE_Q - 1, 1, ONE_Q / 2);
    set_config(MODE_DOWN, 3, 0);
    issue(2, 3000, -ONE_Q / 2, 0, -ONE_Q / 2);
    issue(2, 4000, ONE_Q / 2, 0, ONE_Q / 2);
    // single cell, highest threshold
    set_config(MODE_DIRECT, 0, FIELD_MAX);
    issue(3, 5555, FIELD_MAX, FIELD_MAX, FIELD_MIN);
    issue(3, 6666, 0, FIELD_MAX - 1, 0);
    // oversized size and the modes that never write
    set_config(MODE_REFLECTED, 15, FIELD_MIN);
    issue(4, 1, 0, 0, 0);
    set_config(MODE_SPARE_6, 13, FIELD_MIN);
    issue(4, 2, FIELD_MAX, 0, FIELD_MAX);
    set_config(MODE_SPARE_7, 14, FIELD_MIN);
    issue(4, 3, ONE_Q / 2, 0, ONE_Q / 2);

    // random phases: small stores mostly, a few full-size fill phases
    for (int p = 0; p < PHASES; p++) begin
      if (p % 6 == 5) begin
        mode  = (p % 12 == 5) ? MODE_DOWN_FILL : MODE_UP_FILL;
        size  = $urandom_range(MAX_LOG2_CELLS, 15);
        count = 15;
      end else begin
        mode  = MODE_W'(p % 8);
        size  = $urandom_range(7);
        count = 50;
      end
      case ($urandom_range(4))
        0: thr = FIELD_MIN;
        1: thr = FIELD_MAX;
        2: thr = 0;
        3: thr = int'(THRESHOLD_RESET);
        default: thr = int'(DATA_W'($signed($urandom)));
      endcase
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 68 : 16;
      set_config(mode, size, thr);
      lg = (size > MAX_LOG2_CELLS) ? MAX_LOG2_CELLS : size;
      repeat (count) begin
        while ($urandom_range(99) < idle_pct) begin
          start <= 1'b0;
          @(negedge clk);
        end
        random_item(mode, lg, thr);
      end
    end

    // drain, then let the block settle
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
